// ===== design/point_in_polygon_test_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Point in polygon test unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH
`define POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip assertion failed");

// Next-cycle implication that also holds across reset.
`define PIP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pip assertion failed");

`endif

// ===== design/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point in polygon test unit: package
// Shared types and constants for the vertex store, edge unit and top level.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_W          = 32;
    localparam int IDX_W            = 16;
    localparam int CNT_OUT_W        = 9;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_TEST   = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    // One stored vertex: y in the upper half, x in the lower half.
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    typedef struct packed {
        t_vertex                   v1;
        t_vertex                   v2;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_edge;

    typedef struct packed {
        logic busy;
        logic tgl_valid;
        logic tgl;
    } t_edge_stat;

endpackage

// ===== design/pip_vstore.sv =====
// ----------------------------------------------------------------------------
// Point in polygon test unit: vertex store
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_vstore #(
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF,
    parameter int AW    = 8
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  pip_pkg::t_vertex i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output pip_pkg::t_vertex o_rd_data
);
    import pip_pkg::*;

    t_vertex r_mem [DEPTH];
    t_vertex r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/pip_edge.sv =====
// ----------------------------------------------------------------------------
// Point in polygon test unit: edge crossing unit
// Three-stage pipeline: differences, cross products, compare and crossing flag.
// ----------------------------------------------------------------------------
module pip_edge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_edge_valid,
    input  pip_pkg::t_edge     i_edge,
    output pip_pkg::t_edge_stat o_stat
);
    import pip_pkg::*;

    typedef struct packed {
        logic               neg;
        logic [COORD_W-1:0] mag;
    } t_sm;

    // Difference a - b as sign and magnitude; the magnitude always fits 32 bits.
    function automatic t_sm diff_sm(logic signed [COORD_W-1:0] a,
                                    logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] nd;
        t_sm                     r;
        d     = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        nd    = -d;
        r.neg = d[COORD_W];
        r.mag = d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
        return r;
    endfunction

    // Stage 1
    logic r1_v;
    t_sm  r1_dy, r1_ex, r1_dx, r1_ey;
    logic r1_lt_y2, r1_ge_y1, r1_lt_y1;
    // Stage 2
    logic                 r2_v;
    logic                 r2_ln, r2_rn;
    logic [2*COORD_W-1:0] r2_lm, r2_rm;
    logic                 r2_lt_y2, r2_ge_y1, r2_lt_y1;
    // Stage 3
    logic r3_v;
    logic r3_tgl;

    logic [2*COORD_W-1:0] w_lm, w_rm;
    logic                 w_ln, w_rn, w_gt, w_lt, w_tgl;

    assign w_lm = r1_dy.mag * r1_ex.mag;
    assign w_rm = r1_dx.mag * r1_ey.mag;

    always_comb begin
        // A zero product counts as positive.
        w_ln = r2_ln && (r2_lm != '0);
        w_rn = r2_rn && (r2_rm != '0);
        if (w_ln != w_rn) begin
            w_gt = !w_ln;
            w_lt = w_ln;
        end else begin
            w_gt = (r2_lm != r2_rm) && (w_ln ? (r2_lm < r2_rm) : (r2_lm > r2_rm));
            w_lt = (r2_lm != r2_rm) && (w_ln ? (r2_lm > r2_rm) : (r2_lm < r2_rm));
        end
        priority if (r2_lt_y2) begin
            w_tgl = r2_ge_y1 && w_gt;
        end else if (r2_lt_y1) begin
            w_tgl = w_lt;
        end else begin
            w_tgl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_edge_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dy    <= diff_sm(i_edge.py, i_edge.v1.y);
        r1_ex    <= diff_sm(i_edge.v2.x, i_edge.v1.x);
        r1_dx    <= diff_sm(i_edge.px, i_edge.v1.x);
        r1_ey    <= diff_sm(i_edge.v2.y, i_edge.v1.y);
        r1_lt_y2 <= i_edge.py < i_edge.v2.y;
        r1_ge_y1 <= i_edge.py >= i_edge.v1.y;
        r1_lt_y1 <= i_edge.py < i_edge.v1.y;

        r2_ln    <= r1_dy.neg != r1_ex.neg;
        r2_rn    <= r1_dx.neg != r1_ey.neg;
        r2_lm    <= w_lm;
        r2_rm    <= w_rm;
        r2_lt_y2 <= r1_lt_y2;
        r2_ge_y1 <= r1_ge_y1;
        r2_lt_y1 <= r1_lt_y1;

        r3_tgl   <= w_tgl;
    end

    assign o_stat.busy      = r1_v || r2_v || r3_v;
    assign o_stat.tgl_valid = r3_v;
    assign o_stat.tgl       = r3_tgl;

endmodule

// ===== design/point_in_polygon_test_unit.sv =====
// One word is processed at a time: the next word is taken the cycle after the
// result is registered, and a result waits in S_PUT while an earlier result
// still waits on i_ready. The point test streams one vertex per cycle out of
// the single read port of the vertex store.
// Reset clears the vertex count and all control state; store contents are
// left as they are and become reachable only after being written.
// ----------------------------------------------------------------------------
// Point in polygon test unit: top level
// Vertex list in RAM, even-odd crossing test walking every closed edge.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_mode,
    input  logic signed [pip_pkg::COORD_W-1:0]   i_x_coord,
    input  logic signed [pip_pkg::COORD_W-1:0]   i_y_coord,
    input  logic [pip_pkg::IDX_W-1:0]            i_vertex_index,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_inside_res,
    output logic signed [pip_pkg::COORD_W-1:0]   o_read_x,
    output logic signed [pip_pkg::COORD_W-1:0]   o_read_y,
    output logic [pip_pkg::CNT_OUT_W-1:0]        o_vertex_count,
    output logic                                 o_rejected
);
    import pip_pkg::*;

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDV,
        S_WALK,
        S_WRAP,
        S_DRAIN,
        S_PUT
    } t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_issue;
    logic                      r_rd_pend;
    logic                      r_have_first;
    logic                      r_read_hit;
    t_vertex                   r_v0;
    t_vertex                   r_prev;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic                      r_inside;
    logic                      r_res_inside;
    logic signed [COORD_W-1:0] r_res_x, r_res_y;
    logic                      r_res_rej;
    logic                      r_o_valid;
    logic                      r_o_inside;
    logic signed [COORD_W-1:0] r_o_x, r_o_y;
    logic [CNT_OUT_W-1:0]      r_o_count;
    logic                      r_o_rej;

    logic       w_acc;
    logic       w_full;
    logic       w_in_range;
    logic       w_walk_rd;
    t_mode      w_mode;
    logic       w_wr_en;
    logic       w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_vertex    w_wr_data;
    t_vertex    w_rd_data;
    logic       w_edge_valid;
    t_edge      w_edge;
    t_edge_stat w_stat;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_mode     = t_mode'(i_mode);
    assign w_full     = (r_count == CW'(MAX_VERTICES));
    assign w_in_range = CMPW'(i_vertex_index) < CMPW'(r_count);
    assign w_walk_rd  = (r_state == S_WALK) && (r_issue < r_count);

    assign w_wr_en     = w_acc && (w_mode == MODE_APPEND) && !w_full;
    assign w_wr_data.x = i_x_coord;
    assign w_wr_data.y = i_y_coord;
    assign w_rd_en     = w_walk_rd || (w_acc && (w_mode == MODE_READ) && w_in_range);
    assign w_rd_addr   = w_walk_rd ? r_issue[AW-1:0] : i_vertex_index[AW-1:0];

    // Each returned vertex closes the edge from the one before it; the wrap
    // state closes the polygon back to the first vertex.
    assign w_edge_valid = ((r_state == S_WALK) && r_rd_pend && r_have_first)
                          || (r_state == S_WRAP);
    assign w_edge.v1    = r_prev;
    assign w_edge.v2    = (r_state == S_WRAP) ? r_v0 : w_rd_data;
    assign w_edge.px    = r_px;
    assign w_edge.py    = r_py;

    pip_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pip_edge u_edge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_edge_valid (w_edge_valid),
        .i_edge       (w_edge),
        .o_stat       (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_issue      <= '0;
            r_rd_pend    <= 1'b0;
            r_have_first <= 1'b0;
            r_inside     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_state != S_PUT)) begin
                r_o_valid <= 1'b0;
            end
            r_rd_pend <= w_walk_rd;
            if (w_stat.tgl_valid) begin
                r_inside <= r_inside ^ w_stat.tgl;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res_inside <= 1'b0;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_rej    <= 1'b0;
                        unique case (w_mode)
                            MODE_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_PUT;
                            end
                            MODE_APPEND: begin
                                if (w_full) begin
                                    r_res_rej <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_PUT;
                            end
                            MODE_TEST: begin
                                r_px         <= i_x_coord;
                                r_py         <= i_y_coord;
                                r_issue      <= '0;
                                r_have_first <= 1'b0;
                                r_inside     <= 1'b0;
                                r_state      <= (r_count == '0) ? S_PUT : S_WALK;
                            end
                            MODE_READ: begin
                                r_read_hit <= w_in_range;
                                r_state    <= S_RDV;
                            end
                            default: r_state <= S_PUT;
                        endcase
                    end
                end
                S_RDV: begin
                    r_res_x <= r_read_hit ? w_rd_data.x : '0;
                    r_res_y <= r_read_hit ? w_rd_data.y : '0;
                    r_state <= S_PUT;
                end
                S_WALK: begin
                    if (w_walk_rd) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    if (r_rd_pend) begin
                        if (!r_have_first) begin
                            r_v0         <= w_rd_data;
                            r_have_first <= 1'b1;
                        end
                        r_prev <= w_rd_data;
                    end
                    if (!w_walk_rd && !r_rd_pend) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!w_stat.busy) begin
                        r_res_inside <= r_inside;
                        r_state      <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_inside <= r_res_inside;
                        r_o_x      <= r_res_x;
                        r_o_y      <= r_res_y;
                        r_o_count  <= CNT_OUT_W'(r_count);
                        r_o_rej    <= r_res_rej;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_inside_res   = r_o_inside;
    assign o_read_x       = r_o_x;
    assign o_read_y       = r_o_y;
    assign o_vertex_count = r_o_count;
    assign o_rejected     = r_o_rej;

endmodule

// ===== design/pip_checker.sv =====
// ----------------------------------------------------------------------------
// Point in polygon test unit: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_unit_macros.svh"

module pip_checker #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic [1:0]                         i_mode,
    input logic signed [pip_pkg::COORD_W-1:0] i_x_coord,
    input logic signed [pip_pkg::COORD_W-1:0] i_y_coord,
    input logic [pip_pkg::IDX_W-1:0]          i_vertex_index,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic                               o_inside_res,
    input logic signed [pip_pkg::COORD_W-1:0] o_read_x,
    input logic signed [pip_pkg::COORD_W-1:0] o_read_y,
    input logic [pip_pkg::CNT_OUT_W-1:0]      o_vertex_count,
    input logic                               o_rejected
);
    import pip_pkg::*;

    localparam logic [CNT_OUT_W-1:0] CNT_FULL = CNT_OUT_W'(MAX_VERTICES);

    logic w_in_seen;
    assign w_in_seen = i_valid && o_ready && (i_mode != '0 || i_x_coord != '0
                       || i_y_coord != '0 || i_vertex_index != '0 || 1'b1);

    `PIP_ASSERT_NEXT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n, !o_valid)

    `PIP_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_vertex_count) && $stable(o_inside_res))

    // A rejected append only happens with a full store and carries no other result.
    `PIP_ASSERT_IMPL(a_reject_full, i_clk, i_rst_n, o_valid && o_rejected, o_vertex_count == CNT_FULL && !o_inside_res && o_read_x == '0 && o_read_y == '0)

    // A point test never reports read data alongside the inside flag.
    `PIP_ASSERT_IMPL(a_inside_alone, i_clk, i_rst_n, o_valid && o_inside_res, o_read_x == '0 && o_read_y == '0 && !o_rejected)

    // A word is taken only while no earlier word is still being worked on.
    `PIP_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_seen, !o_ready)

endmodule

bind point_in_polygon_test_unit pip_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_pip_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_mode         (i_mode),
    .i_x_coord      (i_x_coord),
    .i_y_coord      (i_y_coord),
    .i_vertex_index (i_vertex_index),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_inside_res   (o_inside_res),
    .o_read_x       (o_read_x),
    .o_read_y       (o_read_y),
    .o_vertex_count (o_vertex_count),
    .o_rejected     (o_rejected)
);

// ===== bench/tb_point_in_polygon_test_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point in polygon test unit: testbench
// Sends clear, append, point test and vertex read words over the input
// channel and checks every result word against a behavioral copy of the
// vertex list and the even-odd crossing rule. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_unit;
    import pip_pkg::*;

    localparam int MAX_VERTS     = MAX_VERTICES_DEF;
    localparam int RANDOM_WORDS  = 1900;
    localparam int STALL_LIMIT   = 4000;
    localparam int GRID_STEP     = 4194304;   // one degree in Q9.22
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

    typedef struct {
        t_mode                     mode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          idx;
    } t_poly_word;

    typedef struct {
        logic                      in_poly;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic [CNT_OUT_W-1:0]      count;
        logic                      rejected;
    } t_poly_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_mode = MODE_CLEAR;
    logic signed [COORD_W-1:0] i_x_coord = '0;
    logic signed [COORD_W-1:0] i_y_coord = '0;
    logic [IDX_W-1:0]          i_vertex_index = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_inside_res;
    logic signed [COORD_W-1:0] o_read_x;
    logic signed [COORD_W-1:0] o_read_y;
    logic [CNT_OUT_W-1:0]      o_vertex_count;
    logic                      o_rejected;

    t_poly_word  words_to_send[$];
    t_poly_reply replies_due[$];

    // Shadow copy of the polygon held by the block.
    t_vertex     shadow_verts[MAX_VERTS];
    int          shadow_count = 0;

    logic        word_taken = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          words_built = 0;
    int          n_tests = 0;
    int          n_inside = 0;
    int          n_reads = 0;
    int          n_appends = 0;
    int          n_rejects = 0;

    point_in_polygon_test_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_vertex_index (i_vertex_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_res   (o_inside_res),
        .o_read_x       (o_read_x),
        .o_read_y       (o_read_y),
        .o_vertex_count (o_vertex_count),
        .o_rejected     (o_rejected)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    // in which neither side idles at all.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Even-odd crossing count over every closed edge. The side of the edge
    // is decided by an exact compare of two 66-bit cross products.
    function automatic logic ray_parity(logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py);
        t_vertex               a;
        t_vertex               b;
        logic signed [32:0]    dy;
        logic signed [32:0]    ex;
        logic signed [32:0]    dx;
        logic signed [32:0]    ey;
        logic signed [65:0]    lhs;
        logic signed [65:0]    rhs;
        logic                  odd;
        odd = 1'b0;
        for (int k = 0; k < shadow_count; k++) begin
            a  = shadow_verts[k];
            b  = shadow_verts[(k + 1 < shadow_count) ? k + 1 : 0];
            dy = {py[31], py} - {a.y[31], a.y};
            ex = {b.x[31], b.x} - {a.x[31], a.x};
            dx = {px[31], px} - {a.x[31], a.x};
            ey = {b.y[31], b.y} - {a.y[31], a.y};
            lhs = dy * ex;
            rhs = dx * ey;
            if (py < b.y) begin
                if (py >= a.y && lhs > rhs) odd = !odd;
            end else if (py < a.y) begin
                if (lhs < rhs) odd = !odd;
            end
        end
        return odd;
    endfunction

    function automatic t_poly_reply apply_word(t_poly_word w);
        t_poly_reply r;
        r = '{default: '0};
        case (w.mode)
            MODE_CLEAR: begin
                shadow_count = 0;
            end
            MODE_APPEND: begin
                n_appends++;
                if (shadow_count < MAX_VERTS) begin
                    shadow_verts[shadow_count] = '{y: w.y, x: w.x};
                    shadow_count++;
                end else begin
                    r.rejected = 1'b1;
                    n_rejects++;
                end
            end
            MODE_TEST: begin
                r.in_poly = ray_parity(w.x, w.y);
                n_tests++;
                if (r.in_poly) n_inside++;
            end
            default: begin
                n_reads++;
                if (int'(w.idx) < shadow_count) begin
                    r.rx = shadow_verts[w.idx].x;
                    r.ry = shadow_verts[w.idx].y;
                end
            end
        endcase
        r.count = shadow_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: one word at a time from the pending queue.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !word_taken) begin
            // Word not yet accepted; hold it.
        end else if (send_gap != 0) begin
            i_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (words_to_send.size() != 0) begin
            i_mode         <= words_to_send[0].mode;
            i_x_coord      <= words_to_send[0].x;
            i_y_coord      <= words_to_send[0].y;
            i_vertex_index <= words_to_send[0].idx;
            void'(words_to_send.pop_front());
            i_valid  <= 1'b1;
            send_gap <= pick_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // Monitor: results are checked before the input of the same edge is
    // predicted, since a result always belongs to an earlier word.
    always @(posedge i_clk) begin
        t_poly_reply want;
        t_poly_word  w;
        word_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("inside_res", want.in_poly, o_inside_res);
                    check_field("read_x", want.rx, o_read_x);
                    check_field("read_y", want.ry, o_read_y);
                    check_field("vertex_count", want.count, o_vertex_count);
                    check_field("rejected", want.rejected, o_rejected);
                end
            end
            if (i_valid && o_ready) begin
                w = '{mode: t_mode'(i_mode), x: i_x_coord, y: i_y_coord,
                      idx: i_vertex_index};
                replies_due.insert(replies_due.size(), apply_word(w));
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_word(t_mode m, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic [IDX_W-1:0] idx);
        t_poly_word w;
        w = '{mode: m, x: x, y: y, idx: idx};
        words_to_send.insert(words_to_send.size(), w);
        words_built++;
    endtask

    // Coordinate styles: full random, a one-degree grid (lots of shared
    // x and y values and collinear points), and the range corners.
    function automatic logic signed [COORD_W-1:0] pick_coord(int flavor);
        int f;
        f = (flavor > 2) ? $urandom_range(0, 2) : flavor;
        case (f)
            0: return $urandom;
            1: return (int'($urandom_range(0, 12)) - 6) * GRID_STEP
                      + ($urandom_range(0, 3) == 0 ? GRID_STEP / 2 : 0);
            default: begin
                case ($urandom_range(0, 5))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return 32'sd1;
                    default: return C_MIN + 32'sd1;
                endcase
            end
        endcase
    endfunction

    initial begin
        int flavor;
        int nv;
        int nq;
        int r;
        int episode;
        int fills;

        // Directed: empty and tiny polygons, corner coordinates, a triangle
        // spanning the whole range, out-of-range reads and a clear.
        push_word(MODE_CLEAR, C_MAX, C_MIN, 16'hffff);
        push_word(MODE_TEST, 32'sd0, 32'sd0, 16'h0000);
        push_word(MODE_READ, C_MIN, C_MAX, 16'h0000);
        push_word(MODE_APPEND, C_MIN, C_MIN, 16'h0000);
        push_word(MODE_TEST, C_MIN, C_MIN, 16'hffff);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'h0000);
        push_word(MODE_APPEND, C_MAX, C_MAX, 16'hffff);
        push_word(MODE_TEST, 32'sd0, 32'sd0, 16'h0000);
        push_word(MODE_APPEND, C_MAX, C_MIN, 16'h0000);
        push_word(MODE_TEST, 32'sd1073741824, -32'sd1073741824, 16'h0000);
        push_word(MODE_TEST, -32'sd1073741824, 32'sd1073741824, 16'h0000);
        push_word(MODE_TEST, 32'sd0, C_MIN, 16'h0000);
        push_word(MODE_TEST, C_MAX, 32'sd0, 16'h0000);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'd2);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'd3);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'hffff);
        push_word(MODE_APPEND, -32'sd1, 32'sd0, 16'h0000);
        push_word(MODE_APPEND, 32'sd0, -32'sd1, 16'h0000);
        push_word(MODE_TEST, C_MAX, C_MAX, 16'h0000);
        push_word(MODE_TEST, C_MIN, C_MAX, 16'h0000);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'd4);
        push_word(MODE_CLEAR, 32'sd0, 32'sd0, 16'h0000);
        push_word(MODE_READ, 32'sd0, 32'sd0, 16'h0000);
        push_word(MODE_TEST, 32'sd0, 32'sd0, 16'h0000);

        // Random: mostly clear, build a polygon, then query it. Some
        // episodes skip the clear, a few overfill the store so that
        // appends are rejected, and stray words of any mode are mixed in.
        episode = 0;
        fills   = 0;
        while (words_built < RANDOM_WORDS + 24) begin
            flavor = $urandom_range(0, 3);
            if (episode == 5 || (fills < 2 && $urandom_range(0, 99) < 2)) begin
                nv = MAX_VERTS + $urandom_range(1, 3);
                fills++;
            end else if ($urandom_range(0, 9) == 0) begin
                nv = $urandom_range(13, 64);
            end else begin
                nv = $urandom_range(0, 12);
            end
            if ($urandom_range(0, 9) != 0) begin
                push_word(MODE_CLEAR, $urandom, $urandom, IDX_W'($urandom));
            end
            for (int k = 0; k < nv; k++) begin
                push_word(MODE_APPEND, pick_coord(flavor), pick_coord(flavor),
                          IDX_W'($urandom));
            end
            nq = $urandom_range(4, 20);
            for (int k = 0; k < nq; k++) begin
                r = $urandom_range(0, 99);
                if (r < 68) begin
                    push_word(MODE_TEST, pick_coord(flavor), pick_coord(flavor),
                              IDX_W'($urandom));
                end else if (r < 93) begin
                    push_word(MODE_READ, $urandom, $urandom,
                              IDX_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, nv + 2)
                                                                 : $urandom));
                end else begin
                    push_word(t_mode'($urandom_range(0, 3)), $urandom, $urandom,
                              IDX_W'($urandom));
                end
            end
            episode++;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || i_valid) @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d point tests (%0d inside) and %0d vertex reads.",
                 n_tests, n_inside, n_reads);
        $display("Sent %0d appends, %0d of them rejected on a full store; %0d mismatches.",
                 n_appends, n_rejects, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
